FILE: rtl/core/twg_pkg.sv
`default_nettype none

package twg_pkg;

    typedef enum logic [2:0] {
        MODE_ZERO      = 3'd0,
        MODE_NEG_SINE  = 3'd1,
        MODE_COSINE    = 3'd2,
        MODE_IMPULSE   = 3'd3,
        MODE_TRAIN     = 3'd4,
        MODE_CONST     = 3'd5
    } mode_t;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODE             = 3'd0;
    localparam cfg_index_t REG_AMPLITUDE        = 3'd1;
    localparam cfg_index_t REG_PHASE_STEP       = 3'd2;
    localparam cfg_index_t REG_PHASE_OFFSET     = 3'd3;
    localparam cfg_index_t REG_IMPULSE_POSITION = 3'd4;
    localparam cfg_index_t REG_IMPULSE_INTERVAL = 3'd5;
    localparam cfg_index_t REG_FRAME_LENGTH     = 3'd6;

    localparam logic [15:0] AMPLITUDE_RESET = 16'd1;
    localparam logic [15:0] INTERVAL_RESET  = 16'd1;
    localparam logic [16:0] FRAME_RESET     = 17'd1024;
    localparam logic [16:0] FRAME_MAX       = 17'h1_0000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Quarter-wave entry k of 2^tbits: sin(pi/2 * k / 2^tbits) in unsigned Q0.15,
    // odd-power series up to the x^13 term, rounded and capped.
    function automatic logic [14:0] sin_q15(input int unsigned k, input int unsigned tbits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x = (longint'(k) * HALF_PI_Q30) >> tbits;
        term = x;
        sum = x;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd6;
        sum = sum - term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd20;
        sum = sum + term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd42;
        sum = sum - term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd72;
        sum = sum + term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd110;
        sum = sum - term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd156;
        sum = sum + term;
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/test_waveform_generator.sv
`default_nettype none
// Throughput: one sample per cycle; the pipeline holds while the result is not taken.
// Stages: state update, quarter-wave ROM registered read, amplitude multiply,
// round and saturate into the output register.
// Reset: asynchronous, clears all pipeline valids and state, loads register defaults.

module test_waveform_generator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,

    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [twg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire [31:0]                          cfg_data,

    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 restart,

    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic [15:0]                         sample_index,
    output logic                                frame_last
);

    localparam int TBL_N     = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W    = SINE_TABLE_BITS + 1;
    localparam int RND_W     = 18;
    localparam int CMP_W     = (SAMPLE_WIDTH > RND_W) ? SAMPLE_WIDTH : RND_W;
    localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI - CMP_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_N = ADDR_W'(TBL_N);

    // configuration
    logic [2:0]   mode_reg;
    logic [15:0]  amplitude_reg;
    logic [31:0]  phase_step_reg;
    logic [31:0]  phase_offset_reg;
    logic [15:0]  impulse_position_reg;
    logic [15:0]  impulse_interval_reg;
    logic [16:0]  frame_length_reg;

    // generator state
    logic [15:0]  idx_count_reg;
    logic [31:0]  phase_acc_reg;
    logic [15:0]  train_count_reg;
    logic [15:0]  idx_count_next;
    logic [31:0]  phase_acc_next;
    logic [15:0]  train_count_next;

    // pipeline
    logic         s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [31:0]  s1_phase_reg;
    logic         s1_sine_reg, s1_inv_reg, s1_level_reg, s1_last_reg;
    logic [15:0]  s1_idx_reg;
    logic [14:0]  rom_q_reg;
    logic         s2_sine_reg, s2_neg_reg, s2_level_reg, s2_last_reg;
    logic [15:0]  s2_idx_reg;
    logic signed [32:0] s3_prod_reg;
    logic         s3_last_reg;
    logic [15:0]  s3_idx_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [15:0]  sample_index_reg;
    logic         frame_last_reg;

    logic [14:0]  rom [TBL_N+1];

    logic         adv;
    logic         in_fire;
    logic [15:0]  base_idx, base_train, ival_eff;
    logic [31:0]  base_phase;
    logic [16:0]  flen_eff, idx_inc, train_inc;
    logic         last0, sine0, inv0, level0;
    logic [31:0]  phase0;
    logic [SINE_TABLE_BITS-1:0] tbl_a;
    logic [ADDR_W-1:0] rom_addr;
    logic signed [16:0] factor;
    logic signed [32:0] rounded_full;
    logic signed [CMP_W-1:0] rounded;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;

    for (genvar k = 0; k <= TBL_N; k++)
    begin : g_rom
        assign rom[k] = twg_pkg::sin_q15(k, SINE_TABLE_BITS);
    end

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        base_idx   = restart ? 16'd0 : idx_count_reg;
        base_train = restart ? 16'd0 : train_count_reg;
        base_phase = restart ? phase_offset_reg : phase_acc_reg;
        if (frame_length_reg == 17'd0)
        begin
            flen_eff = 17'd1;
        end
        else if (frame_length_reg > twg_pkg::FRAME_MAX)
        begin
            flen_eff = twg_pkg::FRAME_MAX;
        end
        else
        begin
            flen_eff = frame_length_reg;
        end
        ival_eff  = (impulse_interval_reg == 16'd0) ? 16'd1 : impulse_interval_reg;
        idx_inc   = {1'b0, base_idx} + 17'd1;
        train_inc = {1'b0, base_train} + 17'd1;
        last0     = idx_inc >= flen_eff;

        if (last0)
        begin
            idx_count_next   = 16'd0;
            phase_acc_next   = phase_offset_reg;
            train_count_next = 16'd0;
        end
        else
        begin
            idx_count_next   = idx_inc[15:0];
            phase_acc_next   = base_phase + phase_step_reg;
            train_count_next = (train_inc >= {1'b0, ival_eff}) ? 16'd0 : train_inc[15:0];
        end

        sine0  = 1'b0;
        inv0   = 1'b0;
        level0 = 1'b0;
        phase0 = base_phase;
        case (mode_reg)
            twg_pkg::MODE_NEG_SINE:
            begin
                sine0 = 1'b1;
                inv0  = 1'b1;
            end
            twg_pkg::MODE_COSINE:
            begin
                sine0  = 1'b1;
                phase0 = base_phase + 32'h4000_0000;
            end
            twg_pkg::MODE_IMPULSE: level0 = (base_idx == impulse_position_reg);
            twg_pkg::MODE_TRAIN:   level0 = (base_train == 16'd0);
            twg_pkg::MODE_CONST:   level0 = 1'b1;
            default:               level0 = 1'b0;
        endcase
    end

    always_comb
    begin
        tbl_a    = s1_phase_reg[29 -: SINE_TABLE_BITS];
        rom_addr = s1_phase_reg[30] ? (ADDR_N - {1'b0, tbl_a}) : {1'b0, tbl_a};
    end

    always_comb
    begin
        if (s2_sine_reg)
        begin
            factor = s2_neg_reg ? -$signed({2'b00, rom_q_reg}) : $signed({2'b00, rom_q_reg});
        end
        else if (s2_level_reg)
        begin
            factor = 17'sd32768;
        end
        else
        begin
            factor = 17'sd0;
        end
    end

    always_comb
    begin
        rounded_full = (s3_prod_reg + 33'sd16384) >>> 15;
        rounded      = CMP_W'($signed(rounded_full[RND_W-1:0]));
        if (rounded > SAT_HI)
        begin
            sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat_val = rounded[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg             <= twg_pkg::MODE_ZERO;
            amplitude_reg        <= twg_pkg::AMPLITUDE_RESET;
            phase_step_reg       <= 32'd0;
            phase_offset_reg     <= 32'd0;
            impulse_position_reg <= 16'd0;
            impulse_interval_reg <= twg_pkg::INTERVAL_RESET;
            frame_length_reg     <= twg_pkg::FRAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                twg_pkg::REG_MODE:             mode_reg             <= cfg_data[2:0];
                twg_pkg::REG_AMPLITUDE:        amplitude_reg        <= cfg_data[15:0];
                twg_pkg::REG_PHASE_STEP:       phase_step_reg       <= cfg_data;
                twg_pkg::REG_PHASE_OFFSET:     phase_offset_reg     <= cfg_data;
                twg_pkg::REG_IMPULSE_POSITION: impulse_position_reg <= cfg_data[15:0];
                twg_pkg::REG_IMPULSE_INTERVAL: impulse_interval_reg <= cfg_data[15:0];
                twg_pkg::REG_FRAME_LENGTH:     frame_length_reg     <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_count_reg   <= 16'd0;
            phase_acc_reg   <= 32'd0;
            train_count_reg <= 16'd0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (in_fire)
            begin
                idx_count_reg   <= idx_count_next;
                phase_acc_reg   <= phase_acc_next;
                train_count_reg <= train_count_next;
            end
            s1_valid_reg  <= in_fire;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_phase_reg     <= phase0;
            s1_sine_reg      <= sine0;
            s1_inv_reg       <= inv0;
            s1_level_reg     <= level0;
            s1_last_reg      <= last0;
            s1_idx_reg       <= base_idx;

            rom_q_reg        <= rom[rom_addr];
            s2_sine_reg      <= s1_sine_reg;
            s2_neg_reg       <= s1_inv_reg ^ s1_phase_reg[31];
            s2_level_reg     <= s1_level_reg;
            s2_last_reg      <= s1_last_reg;
            s2_idx_reg       <= s1_idx_reg;

            s3_prod_reg      <= factor * $signed(amplitude_reg);
            s3_last_reg      <= s2_last_reg;
            s3_idx_reg       <= s2_idx_reg;

            sample_reg       <= sat_val;
            sample_index_reg <= s3_idx_reg;
            frame_last_reg   <= s3_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_index = sample_index_reg;
    assign frame_last   = frame_last_reg;

    a_wrap_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last0 |=> idx_count_reg == 16'd0 && train_count_reg == 16'd0)
        else $error("index not cleared after last sample of frame");

    a_restart_index: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && restart |=> idx_count_reg <= 16'd1)
        else $error("restart did not reset the sample index");

    a_zero_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg == twg_pkg::MODE_ZERO |-> sample == '0)
        else $error("nonzero sample in zero mode");

endmodule

`default_nettype wire
